FILE: rtl/time_of_day_hms_clock_defines.svh
// ----------------------------------------------------------------------------
// Time-of-day clock assertion macros
// Concurrent checks that drop out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_HMS_CLOCK_DEFINES_SVH
`define TIME_OF_DAY_HMS_CLOCK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every edge outside reset.
`define TOD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("time_of_day_hms_clock: assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define TOD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("time_of_day_hms_clock: assertion failed");

`else

`define TOD_ASSERT(lbl, clk, rst, prop)
`define TOD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/tod_hms_pkg.sv
// ----------------------------------------------------------------------------
// Time-of-day clock package
// Command codes, time types, modulo-day arithmetic and byte residue tables.
// ----------------------------------------------------------------------------
package tod_hms_pkg;

   // Port widths
   localparam int CMD_W      = 3;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;
   localparam int FIELD_W    = 16;
   localparam int OFFSET_W   = 32;
   localparam int TOTAL_W    = 17;
   localparam int DIFF_W     = 18;

   // Time constants
   localparam int DAY_SEC       = 86400;
   localparam int HOUR_SEC      = 3600;
   localparam int MIN_SEC       = 60;
   localparam int HOURS_PER_DAY = 24;
   localparam int HOUR_MAX      = 23;
   localparam int MIN_MAX       = 59;
   localparam int SEC_MAX       = 59;

   // Residue terms summed per item, and the largest carry out of such a sum
   localparam int TERMS      = 6;
   localparam int NORM_STEPS = TERMS - 1;
   localparam int TBL_DEPTH  = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_STRICT = 3'd0,
      CMD_SET_NORM   = 3'd1,
      CMD_NEXT_SEC   = 3'd2,
      CMD_PREV_SEC   = 3'd3,
      CMD_SHIFT      = 3'd4,
      CMD_DIFF       = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      OP_KEEP,
      OP_LOAD,
      OP_ADD,
      OP_DIFF
   } op_type;

   typedef struct packed {
      logic [4:0] hh;
      logic [5:0] mm;
      logic [5:0] ss;
   } hms_type;

   typedef hms_type [TBL_DEPTH-1:0] hms_tbl_type;

   // Add two valid times modulo one day.
   function automatic hms_type hms_add(input hms_type a, input hms_type b);
      hms_type    r;
      logic [6:0] s_sum;
      logic [6:0] m_sum;
      logic [5:0] h_sum;
      logic       s_carry;
      logic       m_carry;
      s_sum   = 7'(a.ss) + 7'(b.ss);
      s_carry = (s_sum >= 7'(MIN_SEC));
      if (s_carry) begin
         s_sum = s_sum - 7'(MIN_SEC);
      end
      m_sum   = 7'(a.mm) + 7'(b.mm) + 7'(s_carry);
      m_carry = (m_sum >= 7'(MIN_SEC));
      if (m_carry) begin
         m_sum = m_sum - 7'(MIN_SEC);
      end
      h_sum = 6'(a.hh) + 6'(b.hh) + 6'(m_carry);
      if (h_sum >= 6'(HOURS_PER_DAY)) begin
         h_sum = h_sum - 6'(HOURS_PER_DAY);
      end
      r.hh = h_sum[4:0];
      r.mm = m_sum[5:0];
      r.ss = s_sum[5:0];
      return r;
   endfunction

   // Fold unnormalized field sums of up to TERMS valid times into one time.
   function automatic hms_type norm_raw(input logic [8:0] ss_raw,
                                        input logic [8:0] mm_raw,
                                        input logic [7:0] hh_raw);
      hms_type    r;
      logic [2:0] qs;
      logic [2:0] qm;
      logic [2:0] qh;
      logic [8:0] ss_rem;
      logic [8:0] mm_sum;
      logic [8:0] mm_rem;
      logic [7:0] hh_sum;
      logic [7:0] hh_rem;
      qs = '0;
      qm = '0;
      qh = '0;
      for (int k = 1; k <= NORM_STEPS; k++) begin
         if (ss_raw >= 9'(k * MIN_SEC)) begin
            qs = 3'(k);
         end
      end
      ss_rem = ss_raw - 9'(qs) * 9'(MIN_SEC);
      mm_sum = mm_raw + 9'(qs);
      for (int k = 1; k <= NORM_STEPS; k++) begin
         if (mm_sum >= 9'(k * MIN_SEC)) begin
            qm = 3'(k);
         end
      end
      mm_rem = mm_sum - 9'(qm) * 9'(MIN_SEC);
      hh_sum = hh_raw + 8'(qm);
      for (int k = 1; k <= NORM_STEPS; k++) begin
         if (hh_sum >= 8'(k * HOURS_PER_DAY)) begin
            qh = 3'(k);
         end
      end
      hh_rem = hh_sum - 8'(qh) * 8'(HOURS_PER_DAY);
      r.hh = hh_rem[4:0];
      r.mm = mm_rem[5:0];
      r.ss = ss_rem[5:0];
      return r;
   endfunction

   // Entry b holds b * step modulo one day; entries of the upper half also
   // take neg, the residue of the byte's negative weight in a signed field.
   function automatic hms_tbl_type build_tbl(input hms_type step, input hms_type neg);
      hms_tbl_type tbl;
      hms_type     acc;
      acc = '0;
      for (int b = 0; b < TBL_DEPTH; b++) begin
         tbl[b[7:0]] = (b >= TBL_DEPTH / 2) ? hms_add(acc, neg) : acc;
         acc = hms_add(acc, step);
      end
      return tbl;
   endfunction

   // Residues of byte weights modulo one day
   localparam longint R_ONE    = 1;
   localparam longint R_B1     = 256 % DAY_SEC;
   localparam longint R_B2     = 65536 % DAY_SEC;
   localparam longint R_B3     = (longint'(1) << 24) % DAY_SEC;
   localparam longint R_B3_NEG = (DAY_SEC - ((longint'(1) << 32) % DAY_SEC)) % DAY_SEC;
   localparam longint R_H_LO   = HOUR_SEC % DAY_SEC;
   localparam longint R_H_HI   = (longint'(HOUR_SEC) * 256) % DAY_SEC;
   localparam longint R_H_NEG  = (DAY_SEC - ((longint'(HOUR_SEC) * 65536) % DAY_SEC)) % DAY_SEC;
   localparam longint R_M_LO   = MIN_SEC % DAY_SEC;
   localparam longint R_M_HI   = (longint'(MIN_SEC) * 256) % DAY_SEC;
   localparam longint R_M_NEG  = (DAY_SEC - ((longint'(MIN_SEC) * 65536) % DAY_SEC)) % DAY_SEC;
   localparam longint R_S_NEG  = (DAY_SEC - (65536 % DAY_SEC)) % DAY_SEC;

   localparam hms_type HMS_ZERO = '0;
   localparam hms_type HMS_ONE  = '{hh: 5'(R_ONE / HOUR_SEC),
      mm: 6'((R_ONE % HOUR_SEC) / MIN_SEC), ss: 6'(R_ONE % MIN_SEC)};
   localparam hms_type HMS_LAST = '{hh: 5'(HOUR_MAX), mm: 6'(MIN_MAX), ss: 6'(SEC_MAX)};
   localparam hms_type HMS_B1   = '{hh: 5'(R_B1 / HOUR_SEC),
      mm: 6'((R_B1 % HOUR_SEC) / MIN_SEC), ss: 6'(R_B1 % MIN_SEC)};
   localparam hms_type HMS_B2   = '{hh: 5'(R_B2 / HOUR_SEC),
      mm: 6'((R_B2 % HOUR_SEC) / MIN_SEC), ss: 6'(R_B2 % MIN_SEC)};
   localparam hms_type HMS_B3   = '{hh: 5'(R_B3 / HOUR_SEC),
      mm: 6'((R_B3 % HOUR_SEC) / MIN_SEC), ss: 6'(R_B3 % MIN_SEC)};
   localparam hms_type HMS_B3_NEG = '{hh: 5'(R_B3_NEG / HOUR_SEC),
      mm: 6'((R_B3_NEG % HOUR_SEC) / MIN_SEC), ss: 6'(R_B3_NEG % MIN_SEC)};
   localparam hms_type HMS_H_LO = '{hh: 5'(R_H_LO / HOUR_SEC),
      mm: 6'((R_H_LO % HOUR_SEC) / MIN_SEC), ss: 6'(R_H_LO % MIN_SEC)};
   localparam hms_type HMS_H_HI = '{hh: 5'(R_H_HI / HOUR_SEC),
      mm: 6'((R_H_HI % HOUR_SEC) / MIN_SEC), ss: 6'(R_H_HI % MIN_SEC)};
   localparam hms_type HMS_H_NEG = '{hh: 5'(R_H_NEG / HOUR_SEC),
      mm: 6'((R_H_NEG % HOUR_SEC) / MIN_SEC), ss: 6'(R_H_NEG % MIN_SEC)};
   localparam hms_type HMS_M_LO = '{hh: 5'(R_M_LO / HOUR_SEC),
      mm: 6'((R_M_LO % HOUR_SEC) / MIN_SEC), ss: 6'(R_M_LO % MIN_SEC)};
   localparam hms_type HMS_M_HI = '{hh: 5'(R_M_HI / HOUR_SEC),
      mm: 6'((R_M_HI % HOUR_SEC) / MIN_SEC), ss: 6'(R_M_HI % MIN_SEC)};
   localparam hms_type HMS_M_NEG = '{hh: 5'(R_M_NEG / HOUR_SEC),
      mm: 6'((R_M_NEG % HOUR_SEC) / MIN_SEC), ss: 6'(R_M_NEG % MIN_SEC)};
   localparam hms_type HMS_S_NEG = '{hh: 5'(R_S_NEG / HOUR_SEC),
      mm: 6'((R_S_NEG % HOUR_SEC) / MIN_SEC), ss: 6'(R_S_NEG % MIN_SEC)};

   // Byte residue tables
   localparam hms_tbl_type TBL_BYTE0 = build_tbl(HMS_ONE, HMS_ZERO);
   localparam hms_tbl_type TBL_BYTE1 = build_tbl(HMS_B1, HMS_ZERO);
   localparam hms_tbl_type TBL_BYTE2 = build_tbl(HMS_B2, HMS_ZERO);
   localparam hms_tbl_type TBL_BYTE3 = build_tbl(HMS_B3, HMS_B3_NEG);
   localparam hms_tbl_type TBL_H_LO  = build_tbl(HMS_H_LO, HMS_ZERO);
   localparam hms_tbl_type TBL_H_HI  = build_tbl(HMS_H_HI, HMS_H_NEG);
   localparam hms_tbl_type TBL_M_LO  = build_tbl(HMS_M_LO, HMS_ZERO);
   localparam hms_tbl_type TBL_M_HI  = build_tbl(HMS_M_HI, HMS_M_NEG);
   localparam hms_tbl_type TBL_S_HI  = build_tbl(HMS_B1, HMS_S_NEG);

endpackage

FILE: rtl/time_of_day_hms_clock.sv
// ----------------------------------------------------------------------------
// Time-of-day clock, 24-hour hh:mm:ss
// Holds the time of day and applies one command per transfer: strict set,
// normalized set, next and previous second, signed shift, difference.
//
//   Channel  Dir  Handshake             Payload
//   req      in   req_tvalid/tready     tuser: cmd; tdata: hours_in, minutes_in,
//                                       seconds_in, offset
//   rsp      out  rsp_tvalid/tready     tdata: hours, minutes, seconds,
//                                       difference; tuser: error
//
// Four register stages from request transfer to result: input register,
// residue sums, normalized delta, result register. One transfer per cycle
// is sustained while the result register is not stalled by rsp_tready.
// The time register is read and written only in the last stage, so each
// command sees the time left by the one before it.
// Synchronous reset empties the pipeline and sets the time to 00:00:00.
// A stalled result holds its stage; bubbles ahead of it still take transfers.
// ----------------------------------------------------------------------------
`include "time_of_day_hms_clock_defines.svh"

module time_of_day_hms_clock (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata, low to high: hours_in[15:0], minutes_in[15:0], seconds_in[15:0], offset[31:0]
   input  logic [tod_hms_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: cmd[2:0]
   input  logic [tod_hms_pkg::CMD_W-1:0]         req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata, low to high: hours[4:0], minutes[5:0], seconds[5:0], difference[17:0],
   // then zero fill to 40 bits
   output logic [tod_hms_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: error
   output logic [tod_hms_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   // ------------------------------------------------------------------
   // Pipeline flow: a stage takes a transfer when it is empty or moves on
   // ------------------------------------------------------------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic rsp_valid_ff;

   logic out_free;
   logic s3_free;
   logic s2_free;
   logic s1_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s3_free    = !s3_valid_ff || out_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;

   // ------------------------------------------------------------------
   // Stage 1: input register
   // ------------------------------------------------------------------
   tod_hms_pkg::cmd_type                  s1_cmd_ff;
   logic [tod_hms_pkg::FIELD_W-1:0]       s1_hours_ff;
   logic [tod_hms_pkg::FIELD_W-1:0]       s1_minutes_ff;
   logic [tod_hms_pkg::FIELD_W-1:0]       s1_seconds_ff;
   logic [tod_hms_pkg::OFFSET_W-1:0]      s1_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_tvalid;
      end
      if (s1_free && req_tvalid) begin
         s1_cmd_ff     <= tod_hms_pkg::cmd_type'(req_tuser);
         s1_hours_ff   <= req_tdata[15:0];
         s1_minutes_ff <= req_tdata[31:16];
         s1_seconds_ff <= req_tdata[47:32];
         s1_offset_ff  <= req_tdata[79:48];
      end
   end

   // ------------------------------------------------------------------
   // Stage 2 logic: pick residue terms per command and add them field-wise
   // ------------------------------------------------------------------
   tod_hms_pkg::hms_type                  term [tod_hms_pkg::TERMS];
   tod_hms_pkg::hms_type                  given_hms;
   logic                                  given_ok;
   tod_hms_pkg::op_type                   s2_op_in;
   logic                                  s2_err_in;
   logic [8:0]                            s2_ss_raw_in;
   logic [8:0]                            s2_mm_raw_in;
   logic [7:0]                            s2_hh_raw_in;
   logic [tod_hms_pkg::TOTAL_W-1:0]       s2_given_in;

   // Upper bits of a negative field make it far above the limits, so an
   // unsigned compare covers both sides of the range.
   assign given_ok = (s1_hours_ff <= 16'(tod_hms_pkg::HOUR_MAX)) &&
                     (s1_minutes_ff <= 16'(tod_hms_pkg::MIN_MAX)) &&
                     (s1_seconds_ff <= 16'(tod_hms_pkg::SEC_MAX));

   assign given_hms = '{hh: s1_hours_ff[4:0], mm: s1_minutes_ff[5:0],
                        ss: s1_seconds_ff[5:0]};

   // Given time as seconds since midnight; meaningful only when in range.
   assign s2_given_in = 17'(s1_hours_ff[4:0]) * 17'(tod_hms_pkg::HOUR_SEC) +
                        17'(s1_minutes_ff[5:0]) * 17'(tod_hms_pkg::MIN_SEC) +
                        17'(s1_seconds_ff[5:0]);

   always_comb begin
      for (int k = 0; k < tod_hms_pkg::TERMS; k++) begin
         term[k] = tod_hms_pkg::HMS_ZERO;
      end
      s2_op_in  = tod_hms_pkg::OP_KEEP;
      s2_err_in = 1'b0;
      unique case (s1_cmd_ff)
         tod_hms_pkg::CMD_SET_STRICT: begin
            if (given_ok) begin
               s2_op_in = tod_hms_pkg::OP_LOAD;
               term[0]  = given_hms;
            end else begin
               s2_err_in = 1'b1;
            end
         end
         tod_hms_pkg::CMD_SET_NORM: begin
            // hours*3600 + minutes*60 + seconds, each byte reduced by table
            s2_op_in = tod_hms_pkg::OP_LOAD;
            term[0]  = tod_hms_pkg::TBL_H_LO[s1_hours_ff[7:0]];
            term[1]  = tod_hms_pkg::TBL_H_HI[s1_hours_ff[15:8]];
            term[2]  = tod_hms_pkg::TBL_M_LO[s1_minutes_ff[7:0]];
            term[3]  = tod_hms_pkg::TBL_M_HI[s1_minutes_ff[15:8]];
            term[4]  = tod_hms_pkg::TBL_BYTE0[s1_seconds_ff[7:0]];
            term[5]  = tod_hms_pkg::TBL_S_HI[s1_seconds_ff[15:8]];
         end
         tod_hms_pkg::CMD_NEXT_SEC: begin
            s2_op_in = tod_hms_pkg::OP_ADD;
            term[0]  = tod_hms_pkg::HMS_ONE;
         end
         tod_hms_pkg::CMD_PREV_SEC: begin
            // minus one second is plus 23:59:59 modulo one day
            s2_op_in = tod_hms_pkg::OP_ADD;
            term[0]  = tod_hms_pkg::HMS_LAST;
         end
         tod_hms_pkg::CMD_SHIFT: begin
            s2_op_in = tod_hms_pkg::OP_ADD;
            term[0]  = tod_hms_pkg::TBL_BYTE0[s1_offset_ff[7:0]];
            term[1]  = tod_hms_pkg::TBL_BYTE1[s1_offset_ff[15:8]];
            term[2]  = tod_hms_pkg::TBL_BYTE2[s1_offset_ff[23:16]];
            term[3]  = tod_hms_pkg::TBL_BYTE3[s1_offset_ff[31:24]];
         end
         tod_hms_pkg::CMD_DIFF: begin
            if (given_ok) begin
               s2_op_in = tod_hms_pkg::OP_DIFF;
            end else begin
               s2_err_in = 1'b1;
            end
         end
         default: begin
            s2_op_in = tod_hms_pkg::OP_KEEP;
         end
      endcase
   end

   always_comb begin
      s2_ss_raw_in = '0;
      s2_mm_raw_in = '0;
      s2_hh_raw_in = '0;
      for (int k = 0; k < tod_hms_pkg::TERMS; k++) begin
         s2_ss_raw_in = s2_ss_raw_in + 9'(term[k].ss);
         s2_mm_raw_in = s2_mm_raw_in + 9'(term[k].mm);
         s2_hh_raw_in = s2_hh_raw_in + 8'(term[k].hh);
      end
   end

   tod_hms_pkg::op_type                   s2_op_ff;
   logic                                  s2_err_ff;
   logic [8:0]                            s2_ss_raw_ff;
   logic [8:0]                            s2_mm_raw_ff;
   logic [7:0]                            s2_hh_raw_ff;
   logic [tod_hms_pkg::TOTAL_W-1:0]       s2_given_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_free && s1_valid_ff) begin
         s2_op_ff     <= s2_op_in;
         s2_err_ff    <= s2_err_in;
         s2_ss_raw_ff <= s2_ss_raw_in;
         s2_mm_raw_ff <= s2_mm_raw_in;
         s2_hh_raw_ff <= s2_hh_raw_in;
         s2_given_ff  <= s2_given_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: carry the raw field sums into one time of day
   // ------------------------------------------------------------------
   tod_hms_pkg::hms_type                  s3_delta_in;
   tod_hms_pkg::op_type                   s3_op_ff;
   logic                                  s3_err_ff;
   tod_hms_pkg::hms_type                  s3_delta_ff;
   logic [tod_hms_pkg::TOTAL_W-1:0]       s3_given_ff;

   assign s3_delta_in = tod_hms_pkg::norm_raw(s2_ss_raw_ff, s2_mm_raw_ff, s2_hh_raw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_free && s2_valid_ff) begin
         s3_op_ff    <= s2_op_ff;
         s3_err_ff   <= s2_err_ff;
         s3_delta_ff <= s3_delta_in;
         s3_given_ff <= s2_given_ff;
      end
   end

   // ------------------------------------------------------------------
   // Last stage: apply to the time register and build the result
   // ------------------------------------------------------------------
   tod_hms_pkg::hms_type                  time_ff;
   tod_hms_pkg::hms_type                  time_in;
   logic [tod_hms_pkg::TOTAL_W-1:0]       cur_total;
   logic [tod_hms_pkg::DIFF_W-1:0]        diff_in;
   logic                                  commit;

   assign commit    = s3_valid_ff && out_free;
   assign cur_total = 17'(time_ff.hh) * 17'(tod_hms_pkg::HOUR_SEC) +
                      17'(time_ff.mm) * 17'(tod_hms_pkg::MIN_SEC) +
                      17'(time_ff.ss);

   always_comb begin
      time_in = time_ff;
      diff_in = '0;
      unique case (s3_op_ff)
         tod_hms_pkg::OP_KEEP: time_in = time_ff;
         tod_hms_pkg::OP_LOAD: time_in = s3_delta_ff;
         tod_hms_pkg::OP_ADD:  time_in = tod_hms_pkg::hms_add(time_ff, s3_delta_ff);
         tod_hms_pkg::OP_DIFF: diff_in = 18'(cur_total) - 18'(s3_given_ff);
      endcase
   end

   tod_hms_pkg::hms_type                  rsp_time_ff;
   logic [tod_hms_pkg::DIFF_W-1:0]        rsp_diff_ff;
   logic                                  rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         time_ff      <= tod_hms_pkg::HMS_ZERO;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= s3_valid_ff;
         end
         // advance the time only when the result moves into the output register
         if (commit) begin
            time_ff <= time_in;
         end
      end
      if (commit) begin
         rsp_time_ff <= time_in;
         rsp_diff_ff <= diff_in;
         rsp_err_ff  <= s3_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_diff_ff, rsp_time_ff.ss, rsp_time_ff.mm, rsp_time_ff.hh};
   assign rsp_tuser  = rsp_err_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   logic time_ok;

   assign time_ok = (time_ff.hh <= 5'(tod_hms_pkg::HOUR_MAX)) &&
                    (time_ff.mm <= 6'(tod_hms_pkg::MIN_MAX)) &&
                    (time_ff.ss <= 6'(tod_hms_pkg::SEC_MAX));

   `TOD_ASSERT(a_time_in_range, clock, reset, time_ok)
   `TOD_ASSERT(a_err_no_diff, clock, reset, !(rsp_valid_ff && rsp_err_ff) || (rsp_diff_ff == '0))
   `TOD_ASSERT_NEXT(a_stall_holds_time, clock, reset, rsp_valid_ff && !rsp_tready, $stable(time_ff))
   `TOD_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_tvalid && req_tready, s1_valid_ff)

endmodule
